/* design/pee_pkg.sv */
// Shared types and constants for the postfix expression evaluator.
package pee_pkg;

  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned RESULT_W = 32;

  localparam logic [OPCODE_W-1:0] OP_PUSH = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_ADD  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_SUB  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_MUL  = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_DIV  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DIV_ZERO  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_LEFTOVER  = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_LOAD,
    S_ITER,
    S_FINISH
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic                tok_load;
    logic                push;
    logic                alu_write;
    logic                unit_start;
    logic                unit_write;
    logic                err_set;
    logic [STATUS_W-1:0] err_code;
    logic                finish;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic                err_held;
    logic                full;
    logic                below_two;
    logic [OPCODE_W-1:0] opcode;
    logic                last;
    logic                rhs_zero;
    logic                unit_done;
    logic                out_blocked;
  } stat_t;

endpackage

/* design/pee_arith.sv */
// Iterative shift-add multiplier and restoring divider, one bit per cycle.
module pee_arith #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic                   is_div_i,
  input  logic [VALUE_WIDTH-1:0] lhs_i,
  input  logic [VALUE_WIDTH-1:0] rhs_i,
  output logic                   done_o,
  output logic [VALUE_WIDTH-1:0] result_o
);

  localparam int unsigned W     = VALUE_WIDTH;
  localparam int unsigned CNT_W = $clog2(W + 1);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             div_q, neg_q;
  logic [W-1:0]     acc_q, acc_d;   // accumulator / remainder
  logic [W-1:0]     quo_q, quo_d;   // multiplier / quotient
  logic [W-1:0]     opd_q, opd_d;   // multiplicand / divisor
  logic [W:0]       trial;
  logic [W-1:0]     lhs_mag, rhs_mag;

  assign lhs_mag = lhs_i[W-1] ? (W'(0) - lhs_i) : lhs_i;
  assign rhs_mag = rhs_i[W-1] ? (W'(0) - rhs_i) : rhs_i;
  assign trial   = {acc_q, quo_q[W-1]} - {1'b0, opd_q};

  always_comb begin
    acc_d  = acc_q;
    quo_d  = quo_q;
    opd_d  = opd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(W);
      acc_d  = '0;
      quo_d  = is_div_i ? lhs_mag : rhs_i;
      opd_d  = is_div_i ? rhs_mag : lhs_i;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - CNT_W'(1);
        if (div_q) begin
          if (!trial[W]) begin
            acc_d = trial[W-1:0];
            quo_d = {quo_q[W-2:0], 1'b1};
          end else begin
            acc_d = {acc_q[W-2:0], quo_q[W-1]};
            quo_d = {quo_q[W-2:0], 1'b0};
          end
        end else begin
          if (quo_q[0]) acc_d = acc_q + opd_q;
          opd_d = {opd_q[W-2:0], 1'b0};
          quo_d = {1'b0, quo_q[W-1:1]};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    quo_q <= quo_d;
    opd_q <= opd_d;
    if (start_i) begin
      div_q <= is_div_i;
      neg_q <= is_div_i & (lhs_i[W-1] ^ rhs_i[W-1]);
    end
  end

  assign done_o   = busy_q && (cnt_q == '0);
  assign result_o = div_q ? (neg_q ? (W'(0) - quo_q) : quo_q) : acc_q;

endmodule

/* design/pee_datapath.sv */
// Operand stack, top-of-stack register, error state and result register.
module pee_datapath #(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [pee_pkg::OPCODE_W-1:0]  opcode_i,
  input  logic [pee_pkg::DIGIT_W-1:0]   digit_i,
  input  logic                          last_i,
  input  logic                          out_ready_i,
  input  pee_pkg::cmd_t                 cmd_i,
  output pee_pkg::stat_t                stat_o,
  output logic                          out_valid_o,
  output logic signed [pee_pkg::RESULT_W-1:0] result_value_o,
  output logic [pee_pkg::STATUS_W-1:0]  status_o
);

  localparam int unsigned W     = VALUE_WIDTH;
  localparam int unsigned IDX_W = $clog2(STACK_DEPTH);
  localparam int unsigned SP_W  = $clog2(STACK_DEPTH + 1);

  // top of stack lives in top_q; entries below it live in mem
  logic [W-1:0]     mem [STACK_DEPTH];
  logic [W-1:0]     rd_q;
  logic [W-1:0]     top_q;
  logic [SP_W-1:0]  sp_q, sp_d;
  logic [pee_pkg::STATUS_W-1:0] err_q, err_d;
  logic [pee_pkg::OPCODE_W-1:0] op_q;
  logic [pee_pkg::DIGIT_W-1:0]  digit_q;
  logic             last_q;
  logic             out_valid_q, out_valid_d;
  logic [pee_pkg::RESULT_W-1:0] value_q;
  logic [pee_pkg::STATUS_W-1:0] status_q;

  logic [SP_W-1:0]  sp_m1;
  logic [IDX_W-1:0] wr_idx, rd_idx;
  logic [W-1:0]     alu_res, unit_res;
  logic             unit_done;
  logic [pee_pkg::STATUS_W-1:0] fin_status;

  assign sp_m1  = sp_q - SP_W'(1);
  assign wr_idx = sp_m1[IDX_W-1:0];
  assign rd_idx = sp_q[IDX_W-1:0] - IDX_W'(2);

  assign alu_res = (op_q == pee_pkg::OP_SUB) ? (rd_q - top_q) : (rd_q + top_q);

  pee_arith #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_arith (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.unit_start),
    .is_div_i(op_q == pee_pkg::OP_DIV),
    .lhs_i   (rd_q),
    .rhs_i   (top_q),
    .done_o  (unit_done),
    .result_o(unit_res)
  );

  // stack memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.push && (sp_q != '0)) mem[wr_idx] <= top_q;
    rd_q <= mem[rd_idx];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tok_load) begin
      op_q    <= opcode_i;
      digit_q <= digit_i;
      last_q  <= last_i;
    end
    if (cmd_i.push)       top_q <= W'(digit_q);
    if (cmd_i.alu_write)  top_q <= alu_res;
    if (cmd_i.unit_write) top_q <= unit_res;
    if (cmd_i.finish) begin
      value_q  <= (fin_status == pee_pkg::ST_OK) ? pee_pkg::RESULT_W'(top_q) : '0;
      status_q <= fin_status;
    end
  end

  always_comb begin
    if (err_q != pee_pkg::ST_OK)   fin_status = err_q;
    else if (sp_q == '0)           fin_status = pee_pkg::ST_UNDERFLOW;
    else if (sp_q != SP_W'(1))     fin_status = pee_pkg::ST_LEFTOVER;
    else                           fin_status = pee_pkg::ST_OK;
  end

  always_comb begin
    sp_d  = sp_q;
    err_d = err_q;
    if (cmd_i.push)                          sp_d = sp_q + SP_W'(1);
    if (cmd_i.alu_write || cmd_i.unit_write) sp_d = sp_m1;
    if (cmd_i.err_set)                       err_d = cmd_i.err_code;
    if (cmd_i.finish) begin
      sp_d  = '0;
      err_d = pee_pkg::ST_OK;
    end
    out_valid_d = cmd_i.finish | (out_valid_q & ~out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q        <= '0;
      err_q       <= pee_pkg::ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      sp_q        <= sp_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    stat_o.err_held    = (err_q != pee_pkg::ST_OK);
    stat_o.full        = (sp_q == SP_W'(STACK_DEPTH));
    stat_o.below_two   = (sp_q < SP_W'(2));
    stat_o.opcode      = op_q;
    stat_o.last        = last_q;
    stat_o.rhs_zero    = (top_q == '0);
    stat_o.unit_done   = unit_done;
    stat_o.out_blocked = out_valid_q & ~out_ready_i;
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = value_q;
  assign status_o       = status_q;

endmodule

/* design/pee_ctrl.sv */
// Token sequencing state machine for the postfix expression evaluator.
module pee_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pee_pkg::stat_t stat_i,
  output pee_pkg::cmd_t  cmd_o
);

  pee_pkg::state_e state_q, state_d;
  logic is_binop;

  assign is_binop = (stat_i.opcode == pee_pkg::OP_ADD) || (stat_i.opcode == pee_pkg::OP_SUB) ||
                    (stat_i.opcode == pee_pkg::OP_MUL) || (stat_i.opcode == pee_pkg::OP_DIV);

  always_comb begin
    state_d = state_q;
    case (state_q)
      pee_pkg::S_IDLE: begin
        if (in_valid_i) state_d = pee_pkg::S_DECODE;
      end
      pee_pkg::S_DECODE: begin
        if (!stat_i.err_held && is_binop && !stat_i.below_two) state_d = pee_pkg::S_LOAD;
        else                                                   state_d = pee_pkg::S_FINISH;
      end
      pee_pkg::S_LOAD: begin
        if ((stat_i.opcode == pee_pkg::OP_MUL) ||
            ((stat_i.opcode == pee_pkg::OP_DIV) && !stat_i.rhs_zero)) begin
          state_d = pee_pkg::S_ITER;
        end else begin
          state_d = pee_pkg::S_FINISH;
        end
      end
      pee_pkg::S_ITER: begin
        if (stat_i.unit_done) state_d = pee_pkg::S_FINISH;
      end
      pee_pkg::S_FINISH: begin
        if (!(stat_i.last && stat_i.out_blocked)) state_d = pee_pkg::S_IDLE;
      end
      default: state_d = pee_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      pee_pkg::S_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.tok_load = in_valid_i;
      end
      pee_pkg::S_DECODE: begin
        if (!stat_i.err_held) begin
          if (stat_i.opcode == pee_pkg::OP_PUSH) begin
            if (stat_i.full) begin
              cmd_o.err_set  = 1'b1;
              cmd_o.err_code = pee_pkg::ST_OVERFLOW;
            end else begin
              cmd_o.push = 1'b1;
            end
          end else if (is_binop && stat_i.below_two) begin
            cmd_o.err_set  = 1'b1;
            cmd_o.err_code = pee_pkg::ST_UNDERFLOW;
          end
        end
      end
      pee_pkg::S_LOAD: begin
        case (stat_i.opcode)
          pee_pkg::OP_ADD, pee_pkg::OP_SUB: cmd_o.alu_write = 1'b1;
          pee_pkg::OP_MUL: cmd_o.unit_start = 1'b1;
          pee_pkg::OP_DIV: begin
            if (stat_i.rhs_zero) begin
              cmd_o.err_set  = 1'b1;
              cmd_o.err_code = pee_pkg::ST_DIV_ZERO;
            end else begin
              cmd_o.unit_start = 1'b1;
            end
          end
          default: cmd_o = '0;
        endcase
      end
      pee_pkg::S_ITER: begin
        cmd_o.unit_write = stat_i.unit_done;
      end
      pee_pkg::S_FINISH: begin
        cmd_o.finish = stat_i.last & ~stat_i.out_blocked;
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= pee_pkg::S_IDLE;
    else         state_q <= state_d;
  end

endmodule

/* design/postfix_expression_evaluator.sv */
// Top level of the postfix (RPN) expression evaluator.
//
// Usage: tokens arrive on the input channel (in_valid_i / in_ready_o) as
// opcode_i, digit_i and last_i. Opcode push places digit_i on the operand
// stack; add, subtract, multiply and divide pop left (deeper) and right
// (top) and push the wrapped VALUE_WIDTH-bit signed result.
// A token with last_i set produces one transfer on the output channel
// (out_valid_o / out_ready_i): result_value_o and status_o. The stack and
// the held error are then cleared for the next expression.
// Steps per token until the next can be taken: push, unknown opcode or
//   error at decode: decode, finish; add, subtract or divide by zero:
//   decode, load, finish; multiply or divide: decode, load, iteration in
//   the one-bit-per-cycle shift-add / restoring divide unit, finish.
// The result of a last token is registered as in_ready_o comes back.
// Receiver stall: the result register holds its transfer; further tokens
// are still accepted and processed, and only the next last token waits
// until the pending result is taken.
// Reset: stack empty, no error, no result pending; stack entries are not
// cleared and their contents are never used before they are written.
module postfix_expression_evaluator #(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [pee_pkg::OPCODE_W-1:0]        opcode_i,
  input  logic [pee_pkg::DIGIT_W-1:0]         digit_i,
  input  logic                                last_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [pee_pkg::RESULT_W-1:0] result_value_o,
  output logic [pee_pkg::STATUS_W-1:0]        status_o
);

  pee_pkg::cmd_t  cmd;
  pee_pkg::stat_t stat;

  // sequencing: one token at a time
  pee_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  // stack, arithmetic and result register
  pee_datapath #(
    .STACK_DEPTH(STACK_DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .opcode_i      (opcode_i),
    .digit_i       (digit_i),
    .last_i        (last_i),
    .out_ready_i   (out_ready_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_valid_o   (out_valid_o),
    .result_value_o(result_value_o),
    .status_o      (status_o)
  );

endmodule
